>>> sv/cges_pkg.sv
// Shared widths, codes and types for the central gravity Euler step pipeline.
package cges_pkg;

    localparam int RAD_W    = 64;              // radicand width into the square root
    localparam int ROOT_W   = 32;              // root width, one bit per stage
    localparam int SQ_STEPS = ROOT_W;
    localparam int REM_W    = ROOT_W + 3;      // partial remainder of the square root
    localparam int NUM_W    = 91;              // gain*mass*|d| << 24
    localparam int DEN_W    = 95;              // |d|^2 * floor(|d|)
    localparam int QB       = 41;              // quotient bits, value capped at 2^40
    localparam int WIDE_W   = DEN_W + QB;

    localparam logic [1:0] CFG_CX   = 2'd0;
    localparam logic [1:0] CFG_CY   = 2'd1;
    localparam logic [1:0] CFG_MASS = 2'd2;
    localparam logic [1:0] CFG_GAIN = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ZDIST = 2'd1;
    localparam logic [1:0] ST_ZMASS = 2'd2;
    localparam logic [1:0] ST_SAT   = 2'd3;

    typedef struct packed {
        logic               vld;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic               negx;
        logic               negy;
        logic               active;
        logic [1:0]         code;
    } t_side;

    typedef struct packed {
        t_side       sd;
        logic [30:0] ux;
        logic [30:0] uy;
        logic [35:0] cm;
        logic [62:0] s;
    } t_mid;

endpackage

>>> sv/central_gravity_euler_step.sv
// Top level: streaming 2D Euler step of one body under a fixed central mass.
// One body beat is accepted per clock and one result beat leaves per clock; the
// pipeline is 81 stages deep (front end 4, square root 32, products 2, divider 41,
// update 2). The one-bit-per-stage square root and the 41-stage quotient unit set
// that depth. The whole pipeline moves on one advance enable: when the output beat
// is held by i_out_stall, every stage holds and o_in_stall is raised.
// Configuration registers (center x/y Q20.12, central mass, gain Q0.16) are read
// live by the stages and must only be written while no body is in flight. Status
// reports zero distance or zero body mass (no pull applied) and saturation, which
// wins.
module central_gravity_euler_step import cges_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [30:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_vel_x,
    input  logic signed [31:0] i_vel_y,
    input  logic [15:0]        i_body_mass,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_next_pos_x,
    output logic signed [31:0] o_next_pos_y,
    output logic signed [31:0] o_next_vel_x,
    output logic signed [31:0] o_next_vel_y,
    output logic [1:0]         o_status
);

    // clamp a wide signed sum to 32 bits; the top bit of the result flags clamping
    function automatic logic [32:0] sat43(input logic signed [42:0] v);
        logic ovf;
        ovf = (v[42:31] != {12{v[31]}});
        if (ovf) return {1'b1, v[42] ? 32'h8000_0000 : 32'h7FFF_FFFF};
        return {1'b0, v[31:0]};
    endfunction

    // configuration registers
    logic [30:0] r_cx;
    logic [30:0] r_cy;
    logic [19:0] r_mass;
    logic [15:0] r_gain;

    logic adv;

    // stage 1: offsets to the center
    logic               r_s1_vld;
    logic signed [31:0] r_s1_px, r_s1_py, r_s1_vx, r_s1_vy;
    logic               r_s1_bmz;
    logic signed [32:0] r_s1_dx, r_s1_dy;

    // stage 2: magnitudes and case decode
    t_side       r_s2;
    logic [30:0] r_s2_ux, r_s2_uy;

    // stage 3: squares and gain*mass
    t_side       r_s3;
    logic [30:0] r_s3_ux, r_s3_uy;
    logic [61:0] r_s3_sqx, r_s3_sqy;
    logic [35:0] r_s3_cm;

    // stage 4: squared distance
    t_mid        r_s4;

    // alongside the square root
    t_mid        r_da [SQ_STEPS];
    logic [ROOT_W-1:0] root;

    // stage 5: partial products
    t_side       r_s5;
    logic [63:0] r_s5_dlo;
    logic [62:0] r_s5_dhi;
    logic [66:0] r_s5_nx, r_s5_ny;

    // stage 6: numerator and denominator
    t_side            r_s6;
    logic [DEN_W-1:0] r_s6_den;
    logic [NUM_W-1:0] r_s6_numx, r_s6_numy;

    // alongside the dividers
    t_side       r_db [QB];
    logic [QB-1:0] qx, qy;

    // stage 7: new velocity
    t_side              r_s7;
    logic signed [31:0] r_s7_nvx, r_s7_nvy;
    logic               r_s7_sat;

    // stage 8: output beat
    logic        r_o_vld;
    logic [31:0] r_o_px, r_o_py, r_o_vx, r_o_vy;
    logic [1:0]  r_o_st;

    // stage 2 decode
    logic signed [32:0] n_ux_full, n_uy_full;
    t_side              n_s2;

    // stage 7/8 arithmetic
    logic signed [42:0] n_ax, n_ay;
    logic [32:0]        n_nvx, n_nvy, n_npx, n_npy;

    // hold every stage while the output beat waits
    assign adv        = !(r_o_vld && i_out_stall);
    assign o_in_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx   <= 31'd671088640;
            r_cy   <= 31'd671088640;
            r_mass <= 20'd100000;
            r_gain <= 16'd6554;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CX:   r_cx   <= i_cfg_data;
                CFG_CY:   r_cy   <= i_cfg_data;
                CFG_MASS: r_mass <= i_cfg_data[19:0];
                CFG_GAIN: r_gain <= i_cfg_data[15:0];
                default:  r_gain <= r_gain;
            endcase
        end
    end

    always_comb begin
        n_ux_full   = r_s1_dx[32] ? -r_s1_dx : r_s1_dx;
        n_uy_full   = r_s1_dy[32] ? -r_s1_dy : r_s1_dy;
        n_s2.vld    = r_s1_vld;
        n_s2.px     = r_s1_px;
        n_s2.py     = r_s1_py;
        n_s2.vx     = r_s1_vx;
        n_s2.vy     = r_s1_vy;
        n_s2.negx   = r_s1_dx[32];
        n_s2.negy   = r_s1_dy[32];
        priority if (r_s1_dx == '0 && r_s1_dy == '0) begin
            n_s2.code = ST_ZDIST;
        end else if (r_s1_bmz) begin
            n_s2.code = ST_ZMASS;
        end else begin
            n_s2.code = ST_OK;
        end
        // a far body gets no pull: its quotient rounds to zero
        n_s2.active = (n_s2.code == ST_OK) && (n_ux_full[32:31] == 2'b00)
                      && (n_uy_full[32:31] == 2'b00);
    end

    always_comb begin
        n_ax  = $signed({2'b00, qx});
        n_ay  = $signed({2'b00, qy});
        if (!r_db[QB-1].active) begin
            n_ax = '0;
            n_ay = '0;
        end else begin
            if (r_db[QB-1].negx) n_ax = -n_ax;
            if (r_db[QB-1].negy) n_ay = -n_ay;
        end
        n_nvx = sat43($signed({{11{r_db[QB-1].vx[31]}}, r_db[QB-1].vx}) + n_ax);
        n_nvy = sat43($signed({{11{r_db[QB-1].vy[31]}}, r_db[QB-1].vy}) + n_ay);
        // position gains floor(new velocity / 16)
        n_npx = sat43($signed({{11{r_s7.px[31]}}, r_s7.px})
                      + $signed({{15{r_s7_nvx[31]}}, r_s7_nvx[31:4]}));
        n_npy = sat43($signed({{11{r_s7.py[31]}}, r_s7.py})
                      + $signed({{15{r_s7_nvy[31]}}, r_s7_nvy[31:4]}));
    end

    cges_isqrt u_sqrt (
        .i_clk  (i_clk),
        .i_adv  (adv),
        .i_rad  ({1'b0, r_s4.s}),
        .o_root (root)
    );

    cges_div u_div_x (
        .i_clk  (i_clk),
        .i_adv  (adv),
        .i_num  (r_s6_numx),
        .i_den  (r_s6_den),
        .o_quot (qx)
    );

    cges_div u_div_y (
        .i_clk  (i_clk),
        .i_adv  (adv),
        .i_num  (r_s6_numy),
        .i_den  (r_s6_den),
        .o_quot (qy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld    <= 1'b0;
            r_s2.vld    <= 1'b0;
            r_s3.vld    <= 1'b0;
            r_s4.sd.vld <= 1'b0;
            for (int k = 0; k < SQ_STEPS; k++) r_da[k].sd.vld <= 1'b0;
            r_s5.vld    <= 1'b0;
            r_s6.vld    <= 1'b0;
            for (int k = 0; k < QB; k++) r_db[k].vld <= 1'b0;
            r_s7.vld    <= 1'b0;
            r_o_vld     <= 1'b0;
        end else if (adv) begin
            // stage 1
            r_s1_vld <= i_in_valid;
            r_s1_px  <= i_pos_x;
            r_s1_py  <= i_pos_y;
            r_s1_vx  <= i_vel_x;
            r_s1_vy  <= i_vel_y;
            r_s1_bmz <= (i_body_mass == '0);
            r_s1_dx  <= $signed({2'b00, r_cx}) - $signed({i_pos_x[31], i_pos_x});
            r_s1_dy  <= $signed({2'b00, r_cy}) - $signed({i_pos_y[31], i_pos_y});
            // stage 2
            r_s2     <= n_s2;
            r_s2_ux  <= n_ux_full[30:0];
            r_s2_uy  <= n_uy_full[30:0];
            // stage 3
            r_s3     <= r_s2;
            r_s3_ux  <= r_s2_ux;
            r_s3_uy  <= r_s2_uy;
            r_s3_sqx <= r_s2_ux * r_s2_ux;
            r_s3_sqy <= r_s2_uy * r_s2_uy;
            r_s3_cm  <= r_gain * r_mass;
            // stage 4
            r_s4.sd  <= r_s3;
            r_s4.ux  <= r_s3_ux;
            r_s4.uy  <= r_s3_uy;
            r_s4.cm  <= r_s3_cm;
            r_s4.s   <= {1'b0, r_s3_sqx} + {1'b0, r_s3_sqy};
            // advance alongside the square root
            r_da[0]  <= r_s4;
            for (int k = 1; k < SQ_STEPS; k++) r_da[k] <= r_da[k-1];
            // stage 5
            r_s5     <= r_da[SQ_STEPS-1].sd;
            r_s5_dlo <= r_da[SQ_STEPS-1].s[31:0] * root;
            r_s5_dhi <= r_da[SQ_STEPS-1].s[62:32] * root;
            r_s5_nx  <= r_da[SQ_STEPS-1].cm * r_da[SQ_STEPS-1].ux;
            r_s5_ny  <= r_da[SQ_STEPS-1].cm * r_da[SQ_STEPS-1].uy;
            // stage 6
            r_s6      <= r_s5;
            r_s6_den  <= {r_s5_dhi, 32'd0} + {31'd0, r_s5_dlo};
            r_s6_numx <= {r_s5_nx, 24'd0};
            r_s6_numy <= {r_s5_ny, 24'd0};
            // advance alongside the dividers
            r_db[0]  <= r_s6;
            for (int k = 1; k < QB; k++) r_db[k] <= r_db[k-1];
            // stage 7
            r_s7     <= r_db[QB-1];
            r_s7_nvx <= n_nvx[31:0];
            r_s7_nvy <= n_nvy[31:0];
            r_s7_sat <= n_nvx[32] | n_nvy[32];
            // stage 8
            r_o_vld  <= r_s7.vld;
            r_o_px   <= n_npx[31:0];
            r_o_py   <= n_npy[31:0];
            r_o_vx   <= r_s7_nvx;
            r_o_vy   <= r_s7_nvy;
            r_o_st   <= (r_s7_sat | n_npx[32] | n_npy[32]) ? ST_SAT : r_s7.code;
        end
    end

    assign o_out_valid  = r_o_vld;
    assign o_next_pos_x = r_o_px;
    assign o_next_pos_y = r_o_py;
    assign o_next_vel_x = r_o_vx;
    assign o_next_vel_y = r_o_vy;
    assign o_status     = r_o_st;

endmodule

>>> sv/cges_isqrt.sv
// Pipelined integer square root, one root bit resolved per stage.
module cges_isqrt import cges_pkg::*; (
    input  logic              i_clk,
    input  logic              i_adv,
    input  logic [RAD_W-1:0]  i_rad,
    output logic [ROOT_W-1:0] o_root
);

    logic [RAD_W-1:0]  r_rad  [SQ_STEPS];
    logic [REM_W-1:0]  r_rem  [SQ_STEPS];
    logic [ROOT_W-1:0] r_root [SQ_STEPS];

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_stage
        logic [RAD_W-1:0]  w_rad;
        logic [REM_W-1:0]  w_rem;
        logic [REM_W-1:0]  w_rem2;
        logic [REM_W-1:0]  w_trial;
        logic [ROOT_W-1:0] w_root;

        if (k == 0) begin : g_first
            assign w_rad  = i_rad;
            assign w_rem  = '0;
            assign w_root = '0;
        end else begin : g_next
            assign w_rad  = r_rad[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_root = r_root[k-1];
        end

        // bring down the next two radicand bits, try root*4+1
        assign w_rem2  = {w_rem[REM_W-3:0], w_rad[RAD_W-1 -: 2]};
        assign w_trial = {{(REM_W-ROOT_W-2){1'b0}}, w_root, 2'b01};

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rad[k] <= w_rad << 2;
                if (w_rem2 >= w_trial) begin
                    r_rem[k]  <= w_rem2 - w_trial;
                    r_root[k] <= {w_root[ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem[k]  <= w_rem2;
                    r_root[k] <= {w_root[ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_root = r_root[SQ_STEPS-1];

endmodule

>>> sv/cges_div.sv
// Pipelined restoring divider, one quotient bit per stage, quotient capped at 2^40.
module cges_div import cges_pkg::*; (
    input  logic              i_clk,
    input  logic              i_adv,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    output logic [QB-1:0]     o_quot
);

    localparam logic [QB-1:0] Q_CAP = {1'b1, {(QB-1){1'b0}}};

    logic [NUM_W-1:0] r_rem [QB];
    logic [DEN_W-1:0] r_den [QB];
    logic [QB-1:0]    r_q   [QB];
    logic             r_cap [QB];

    for (genvar j = 0; j < QB; j++) begin : g_stage
        localparam int K = QB - 1 - j;
        logic [NUM_W-1:0]  w_rem;
        logic [DEN_W-1:0]  w_den;
        logic [QB-1:0]     w_q;
        logic              w_cap;
        logic [WIDE_W-1:0] w_ext;
        logic [WIDE_W-1:0] w_sh;
        logic [WIDE_W-1:0] w_diff;
        logic              w_ge;

        if (j == 0) begin : g_first
            assign w_rem = i_num;
            assign w_den = i_den;
            assign w_q   = '0;
            // quotient at or beyond 2^41: saturate, remaining bits are ignored
            assign w_cap = {{(WIDE_W-NUM_W){1'b0}}, i_num} >= {i_den, {QB{1'b0}}};
        end else begin : g_next
            assign w_rem = r_rem[j-1];
            assign w_den = r_den[j-1];
            assign w_q   = r_q[j-1];
            assign w_cap = r_cap[j-1];
        end

        assign w_ext  = {{(WIDE_W-NUM_W){1'b0}}, w_rem};
        assign w_sh   = {{QB{1'b0}}, w_den} << K;
        assign w_ge   = w_ext >= w_sh;
        assign w_diff = w_ext - w_sh;

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rem[j] <= w_ge ? w_diff[NUM_W-1:0] : w_rem;
                r_den[j] <= w_den;
                r_q[j]   <= w_q | ({{(QB-1){1'b0}}, w_ge} << K);
                r_cap[j] <= w_cap;
            end
        end
    end

    assign o_quot = (r_cap[QB-1] || (r_q[QB-1] > Q_CAP)) ? Q_CAP : r_q[QB-1];

endmodule

>>> test/tb_central_gravity_euler_step.sv
// Self-checking testbench for the central gravity Euler step pipeline.
module tb_central_gravity_euler_step;
    import cges_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 120;    // beyond the 81-stage pipeline depth
    localparam int PHASE_ITEMS  = 200;

    typedef struct {
        logic signed [31:0] px, py, vx, vy;
        logic [1:0]         st;
    } t_body_next;

    typedef struct {
        logic signed [31:0] px, py, vx, vy;
        logic [15:0]        mass;
        bit                 typed;
        t_body_next         want;
    } t_body_row;

    logic               i_clk = 1'b0, i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_idx = CFG_CX;
    logic [30:0]        i_cfg_data = '0;
    logic               i_in_valid = 1'b0, i_out_stall = 1'b0;
    logic signed [31:0] i_pos_x = '0, i_pos_y = '0, i_vel_x = '0, i_vel_y = '0;
    logic [15:0]        i_body_mass = '0;
    logic               o_in_stall, o_out_valid;
    logic signed [31:0] o_next_pos_x, o_next_pos_y, o_next_vel_x, o_next_vel_y;
    logic [1:0]         o_status;

    // Shadow copies of the configuration registers
    logic [30:0] cen_x = 31'd671088640, cen_y = 31'd671088640;
    logic [19:0] cen_mass = 20'd100000;
    logic [15:0] gain = 16'd6554;

    t_body_next  pending_steps[$];
    int          cycle_cnt = 0, fail_cnt = 0, body_cnt = 0, step_cnt = 0;
    bit          quiet = 1'b0;
    t_body_row   rows[$];

    central_gravity_euler_step i_dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] res, onebit, rem;
        res = 0;
        rem = v;
        onebit = 64'h4000_0000_0000_0000;
        while (onebit > rem) onebit >>= 2;
        while (onebit != 0) begin
            if (rem >= res + onebit) begin
                rem -= res + onebit;
                res = (res >> 1) + onebit;
            end else begin
                res >>= 1;
            end
            onebit >>= 2;
        end
        return res;
    endfunction

    function automatic longint clamp32(input longint v, inout bit sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Next state of one body under the current register values
    function automatic t_body_next euler_step(input t_body_row b);
        t_body_next  n;
        longint      pxl, pyl, dx, dy, ax, ay, nvx, nvy, npx, npy;
        logic [63:0] ux, uy, s, r;
        logic [127:0] c, q;
        bit          sat;
        pxl = b.px;
        pyl = b.py;
        dx = longint'({33'd0, cen_x}) - pxl;
        dy = longint'({33'd0, cen_y}) - pyl;
        ux = dx < 0 ? -dx : dx;
        uy = dy < 0 ? -dy : dy;
        ax = 0;
        ay = 0;
        sat = 1'b0;
        n.st = ST_OK;
        if (ux == 0 && uy == 0) begin
            n.st = ST_ZDIST;
        end else if (b.mass == 0) begin
            n.st = ST_ZMASS;
        end else if (ux < 64'h8000_0000 && uy < 64'h8000_0000) begin
            s = ux * ux + uy * uy;
            r = isqrt64(s);
            c = {64'd0, 64'(gain) * 64'(cen_mass)} << 24;
            q = (c * {64'd0, ux}) / ({64'd0, s} * {64'd0, r});
            if (q > (128'd1 << 40)) q = 128'd1 << 40;
            ax = dx < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
            q = (c * {64'd0, uy}) / ({64'd0, s} * {64'd0, r});
            if (q > (128'd1 << 40)) q = 128'd1 << 40;
            ay = dy < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
        end
        nvx = clamp32(longint'(b.vx) + ax, sat);
        nvy = clamp32(longint'(b.vy) + ay, sat);
        npx = clamp32(pxl + (nvx >>> 4), sat);
        npy = clamp32(pyl + (nvy >>> 4), sat);
        if (sat) n.st = ST_SAT;
        n.px = npx[31:0];
        n.py = npy[31:0];
        n.vx = nvx[31:0];
        n.vy = nvy[31:0];
        return n;
    endfunction

    // Hold the beat until the pipeline takes it, then log its expected step
    task automatic send_body(input t_body_row b);
        while (!quiet && $urandom_range(0, 99) < 8) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_pos_x     <= b.px;
        i_pos_y     <= b.py;
        i_vel_x     <= b.vx;
        i_vel_y     <= b.vy;
        i_body_mass <= b.mass;
        do @(posedge i_clk); while (o_in_stall);
        pending_steps = {pending_steps, (b.typed ? b.want : euler_step(b))};
        body_cnt++;
    endtask

    // Drop valid, drain the pipeline, then write one register
    task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_steps.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_CX:   cen_x    = val;
            CFG_CY:   cen_y    = val;
            CFG_MASS: cen_mass = val[19:0];
            CFG_GAIN: gain     = val[15:0];
        endcase
    endtask

    function automatic t_body_row random_body();
        t_body_row b;
        int        sh;
        b.typed = 1'b0;
        b.want  = '{default: '0};
        if ($urandom_range(0, 9) < 7) begin
            // mostly bodies in orbit range of the center, random spread
            sh = $urandom_range(0, 31);
            b.px = $signed({1'b0, cen_x}) + ($signed($urandom) >>> sh);
            sh = $urandom_range(0, 31);
            b.py = $signed({1'b0, cen_y}) + ($signed($urandom) >>> sh);
            sh = $urandom_range(4, 31);
            b.vx = $signed($urandom) >>> sh;
            sh = $urandom_range(4, 31);
            b.vy = $signed($urandom) >>> sh;
        end else begin
            b.px = $urandom;
            b.py = $urandom;
            b.vx = $urandom;
            b.vy = $urandom;
        end
        if ($urandom_range(0, 49) == 0) begin
            b.px = cen_x;
            b.py = cen_y;
        end
        b.mass = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom);
        return b;
    endfunction

    function automatic t_body_row mk_row(input logic signed [31:0] px, py, vx, vy,
                                         input logic [15:0] m);
        t_body_row b;
        b.px = px;
        b.py = py;
        b.vx = vx;
        b.vy = vy;
        b.mass = m;
        b.typed = 1'b0;
        b.want = '{default: '0};
        return b;
    endfunction

    function automatic t_body_row mk_typed(input t_body_row b,
                                           input logic signed [31:0] px, py, vx, vy,
                                           input logic [1:0] st);
        b.typed = 1'b1;
        b.want = '{px: px, py: py, vx: vx, vy: vy, st: st};
        return b;
    endfunction

    // Check each result beat against the oldest expected step
    always @(posedge i_clk) begin
        t_body_next w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_steps.size() == 0) begin
                $error("result beat with no body in flight");
                fail_cnt++;
            end else begin
                w = pending_steps.pop_front();
                step_cnt++;
                if (o_next_pos_x !== w.px) begin
                    $error("next_pos_x: expected %0d, got %0d", w.px, o_next_pos_x);
                    fail_cnt++;
                end
                if (o_next_pos_y !== w.py) begin
                    $error("next_pos_y: expected %0d, got %0d", w.py, o_next_pos_y);
                    fail_cnt++;
                end
                if (o_next_vel_x !== w.vx) begin
                    $error("next_vel_x: expected %0d, got %0d", w.vx, o_next_vel_x);
                    fail_cnt++;
                end
                if (o_next_vel_y !== w.vy) begin
                    $error("next_vel_y: expected %0d, got %0d", w.vy, o_next_vel_y);
                    fail_cnt++;
                end
                if (o_status !== w.st) begin
                    $error("status: expected %0d, got %0d", w.st, o_status);
                    fail_cnt++;
                end
            end
        end
        i_out_stall <= !quiet && ($urandom_range(0, 99) < 8);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        t_body_row b;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows under reset register values
        // body on the center: no pull, position and velocity kept
        rows = {rows, mk_typed(mk_row(671088640, 671088640, 0, 0, 16'd1),
                               671088640, 671088640, 0, 0, ST_ZDIST)};
        // massless body: no pull
        rows = {rows, mk_typed(mk_row(0, 0, 0, 0, 16'd0), 0, 0, 0, 0, ST_ZMASS)};
        // saturation on position overrides zero mass
        rows = {rows, mk_typed(mk_row(32'h7fffffff, 0, 32'h7fffffff, 0, 16'd0),
                               32'h7fffffff, 0, 32'h7fffffff, 0, ST_SAT)};
        rows = {rows, mk_typed(mk_row(32'h80000000, 0, 32'h80000000, 0, 16'd0),
                               32'h80000000, 0, 32'h80000000, 0, ST_SAT)};
        // far body: distance beyond 2^31 gives no pull
        rows = {rows, mk_typed(mk_row(32'h80000000, 0, 0, 0, 16'd1),
                               32'h80000000, 0, 0, 0, ST_OK)};
        rows = {rows, mk_row(671088640 + 4096, 671088640, 0, 0, 16'hffff)};
        rows = {rows, mk_row(671088640, 671088640 - 1, 0, 0, 16'd1)};
        rows = {rows, mk_row(671088641, 671088641, 32'h7fffffff, 32'h80000000, 16'd256)};
        rows = {rows, mk_row(0, 32'h7fffffff, 32'hffffffff, 1, 16'h8000)};
        rows = {rows, mk_row(32'hffffffff, 32'h80000001, 16, -16, 16'd1)};
        rows = {rows, mk_row(671088640 - 40960, 671088640 + 40960, 65536, -65536, 16'd7)};
        rows = {rows, mk_row(32'h55555555, 32'haaaaaaaa, 32'haaaaaaaa, 32'h55555555,
                             16'h5555)};
        rows = {rows, mk_row(32'haaaaaaaa, 32'h55555555, 32'h55555555, 32'haaaaaaaa,
                             16'haaaa)};
        foreach (rows[k]) send_body(rows[k]);

        // Random phases, each under its own register setting
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: begin end
                1: begin
                    write_reg(CFG_CX, 31'd0);
                    write_reg(CFG_CY, 31'd0);
                end
                2: begin
                    write_reg(CFG_CX, 31'd1342177280);
                    write_reg(CFG_CY, 31'd1342177280);
                    write_reg(CFG_MASS, 31'd1048575);
                    write_reg(CFG_GAIN, 31'd65535);
                end
                3: write_reg(CFG_MASS, 31'd0);
                4: begin
                    write_reg(CFG_MASS, 31'd1);
                    write_reg(CFG_GAIN, 31'd0);
                end
                default: begin
                    write_reg(CFG_CX, 31'($urandom_range(0, 1342177280)));
                    write_reg(CFG_CY, 31'($urandom_range(0, 1342177280)));
                    write_reg(CFG_MASS, 31'($urandom_range(0, 1048575)));
                    write_reg(CFG_GAIN, 31'($urandom_range(0, 65535)));
                end
            endcase
            quiet = (ph == 4);    // one phase runs with both sides at full rate
            repeat (PHASE_ITEMS) begin
                b = random_body();
                send_body(b);
            end
            quiet = 1'b0;
        end

        i_in_valid <= 1'b0;
        while (pending_steps.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Stepped %0d bodies (%0d results checked) across seven register settings,",
                 body_cnt, step_cnt);
        $display("covering zero distance, zero mass, far bodies, saturation and zero pull.");
        if (fail_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
